>>> rtl/eipf_pkg.sv
// Package for the Ethernet/IPv4 L4 header filter.
// Holds the verdict codes, header offsets and field widths; no dependencies.
package eipf_pkg;

  typedef enum logic [3:0] {
    VERDICT_PASS     = 4'd0,
    VERDICT_NOT_IPV4 = 4'd1,
    VERDICT_SRC_IP   = 4'd2,
    VERDICT_DST_IP   = 4'd3,
    VERDICT_FRAG     = 4'd4,
    VERDICT_PROTO    = 4'd5,
    VERDICT_SPORT    = 4'd6,
    VERDICT_DPORT    = 4'd7,
    VERDICT_TRUNC    = 4'd8
  } verdict_e;

  typedef enum logic [2:0] {
    CFG_SRC_IP_MATCH   = 3'd0,
    CFG_SRC_IP_ENABLE  = 3'd1,
    CFG_DST_IP_MATCH   = 3'd2,
    CFG_DST_IP_ENABLE  = 3'd3,
    CFG_SRC_PORT_MATCH = 3'd4,
    CFG_DST_PORT_MATCH = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 168;

  localparam logic [7:0] EthTypeHi = 8'h08;
  localparam logic [7:0] EthTypeLo = 8'h00;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [3:0] MinIhl    = 4'd5;
  localparam logic [6:0] IpStart   = 7'd14;

  // frame byte offsets
  localparam logic [15:0] PosEthTypeHi = 16'd12;
  localparam logic [15:0] PosEthTypeLo = 16'd13;
  localparam logic [15:0] PosVerIhl    = 16'd14;
  localparam logic [15:0] PosTotLenHi  = 16'd16;
  localparam logic [15:0] PosTotLenLo  = 16'd17;
  localparam logic [15:0] PosFragHi    = 16'd20;
  localparam logic [15:0] PosFragLo    = 16'd21;
  localparam logic [15:0] PosTtl       = 16'd22;
  localparam logic [15:0] PosProto     = 16'd23;
  localparam logic [15:0] PosSrc0      = 16'd26;
  localparam logic [15:0] PosSrc1      = 16'd27;
  localparam logic [15:0] PosSrc2      = 16'd28;
  localparam logic [15:0] PosSrc3      = 16'd29;
  localparam logic [15:0] PosDst0      = 16'd30;
  localparam logic [15:0] PosDst1      = 16'd31;
  localparam logic [15:0] PosDst2      = 16'd32;
  localparam logic [15:0] PosDst3      = 16'd33;
  localparam logic [15:0] PosL4Min     = 16'd34;

  // offsets inside the transport header
  localparam logic [15:0] RelSportHi = 16'd0;
  localparam logic [15:0] RelSportLo = 16'd1;
  localparam logic [15:0] RelDportHi = 16'd2;
  localparam logic [15:0] RelDportLo = 16'd3;
  localparam logic [15:0] RelUdpLenHi = 16'd4;
  localparam logic [15:0] RelUdpLenLo = 16'd5;
  localparam logic [15:0] RelTcpFlags = 16'd13;

endpackage

>>> rtl/eth_ipv4_l4_header_filter_top.sv
// Ethernet/IPv4 TCP-UDP header filter, top level.
// Depends on eipf_pkg for verdict codes and header offsets.
//
// Takes one frame byte per beat, starting at the destination MAC, and gives
// one result beat per frame, registered from the beat that carries tlast.
// The parser state registers are updated by a single level of compare and
// select logic per byte, so a byte is taken on every clock; the only stall
// comes from the output register, which holds a finished result until the
// sink takes it while the next frame keeps flowing in; only that frame's
// last byte waits for the register to free up. Filters are set through the
// write port between frames; a port match of zero disables that port check.
// Frames that end before a decision report truncated.
module eth_ipv4_l4_header_filter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [eipf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [eipf_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // data_byte
  input  logic                              s_axis_tuser,   // frame_start
  input  logic                              s_axis_tlast,   // frame_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // verdict, total_length, frag_offset, time_to_live, ip_protocol, source_ip,
  // dest_ip, source_port, dest_port, tcp_syn, tcp_fin, udp_length, zero pad
  output logic [eipf_pkg::OutDataW-1:0]     m_axis_tdata
);
  import eipf_pkg::*;

  logic [31:0] src_ip_match_q, dst_ip_match_q;
  logic        src_ip_en_q, dst_ip_en_q;
  logic [15:0] src_port_match_q, dst_port_match_q;

  logic [15:0] pos_q, pos_d;
  logic [3:0]  hdr_words_q, hdr_words_d;
  verdict_e    verdict_q, verdict_d;
  logic [15:0] tot_len_q, tot_len_d;
  logic [12:0] frag_q, frag_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_ip_q, src_ip_d;
  logic [31:0] dst_ip_q, dst_ip_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic        syn_q, syn_d, fin_q, fin_d;
  logic [15:0] udp_len_q, udp_len_d;
  logic [7:0]  scratch_q, scratch_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic        beat;
  logic [7:0]  b;
  logic [15:0] pos_c, rel;
  logic [3:0]  words;
  logic [6:0]  l4_start;
  logic [15:0] pair;

  // only a last byte needs the output register
  assign s_axis_tready = !out_valid_q || m_axis_tready || !s_axis_tlast;
  assign beat          = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_ip_match_q   <= '0;
      src_ip_en_q      <= 1'b0;
      dst_ip_match_q   <= '0;
      dst_ip_en_q      <= 1'b0;
      src_port_match_q <= '0;
      dst_port_match_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_IP_MATCH:   src_ip_match_q   <= cfg_data_i;
        CFG_SRC_IP_ENABLE:  src_ip_en_q      <= cfg_data_i[0];
        CFG_DST_IP_MATCH:   dst_ip_match_q   <= cfg_data_i;
        CFG_DST_IP_ENABLE:  dst_ip_en_q      <= cfg_data_i[0];
        CFG_SRC_PORT_MATCH: src_port_match_q <= cfg_data_i[15:0];
        CFG_DST_PORT_MATCH: dst_port_match_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d       = pos_q;
    hdr_words_d = hdr_words_q;
    verdict_d   = verdict_q;
    tot_len_d   = tot_len_q;
    frag_d      = frag_q;
    ttl_d       = ttl_q;
    proto_d     = proto_q;
    src_ip_d    = src_ip_q;
    dst_ip_d    = dst_ip_q;
    sport_d     = sport_q;
    dport_d     = dport_q;
    syn_d       = syn_q;
    fin_d       = fin_q;
    udp_len_d   = udp_len_q;
    scratch_d   = scratch_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    pos_c       = '0;
    words       = '0;
    l4_start    = '0;
    rel         = '0;
    pair        = '0;

    if (beat) begin
      if (s_axis_tuser) begin
        pos_d       = '0;
        hdr_words_d = '0;
        verdict_d   = VERDICT_TRUNC;
        tot_len_d   = '0;
        frag_d      = '0;
        ttl_d       = '0;
        proto_d     = '0;
        src_ip_d    = '0;
        dst_ip_d    = '0;
        sport_d     = '0;
        dport_d     = '0;
        syn_d       = 1'b0;
        fin_d       = 1'b0;
        udp_len_d   = '0;
        scratch_d   = '0;
      end

      pos_c    = pos_d;
      pair     = {scratch_d, b};
      words    = (hdr_words_d < MinIhl) ? MinIhl : hdr_words_d;
      l4_start = IpStart + {1'b0, words, 2'b00};
      rel      = pos_c - {9'd0, l4_start};

      if (verdict_d == VERDICT_TRUNC) begin
        priority if (pos_c == PosEthTypeHi) begin
          if (b != EthTypeHi) verdict_d = VERDICT_NOT_IPV4;
        end else if (pos_c == PosEthTypeLo) begin
          if (b != EthTypeLo) verdict_d = VERDICT_NOT_IPV4;
        end else if (pos_c == PosVerIhl) begin
          hdr_words_d = b[3:0];
        end else if (pos_c == PosTotLenHi || pos_c == PosFragHi) begin
          scratch_d = b;
        end else if (pos_c == PosTotLenLo) begin
          tot_len_d = pair;
        end else if (pos_c == PosFragLo) begin
          frag_d = {scratch_d[4:0], b};
        end else if (pos_c == PosTtl) begin
          ttl_d = b;
        end else if (pos_c == PosProto) begin
          proto_d = b;
        end else if (pos_c == PosSrc0) begin
          src_ip_d[31:24] = b;
        end else if (pos_c == PosSrc1) begin
          src_ip_d[23:16] = b;
        end else if (pos_c == PosSrc2) begin
          src_ip_d[15:8] = b;
        end else if (pos_c == PosSrc3) begin
          src_ip_d[7:0] = b;
          if (src_ip_en_q && src_ip_d != src_ip_match_q) verdict_d = VERDICT_SRC_IP;
        end else if (pos_c == PosDst0) begin
          dst_ip_d[31:24] = b;
        end else if (pos_c == PosDst1) begin
          dst_ip_d[23:16] = b;
        end else if (pos_c == PosDst2) begin
          dst_ip_d[15:8] = b;
        end else if (pos_c == PosDst3) begin
          dst_ip_d[7:0] = b;
          priority if (dst_ip_en_q && dst_ip_d != dst_ip_match_q) begin
            verdict_d = VERDICT_DST_IP;
          end else if (frag_d != '0) begin
            verdict_d = VERDICT_FRAG;
          end else if (proto_d != ProtoTcp && proto_d != ProtoUdp) begin
            verdict_d = VERDICT_PROTO;
          end else begin
          end
        end else if (pos_c >= PosL4Min && pos_c >= {9'd0, l4_start}) begin
          priority if (rel == RelSportHi || rel == RelDportHi || rel == RelUdpLenHi) begin
            scratch_d = b;
          end else if (rel == RelSportLo) begin
            sport_d = pair;
            if (src_port_match_q != '0 && pair != src_port_match_q) verdict_d = VERDICT_SPORT;
          end else if (rel == RelDportLo) begin
            dport_d = pair;
            if (dst_port_match_q != '0 && pair != dst_port_match_q) verdict_d = VERDICT_DPORT;
          end else if (rel == RelUdpLenLo && proto_d == ProtoUdp) begin
            udp_len_d = pair;
            verdict_d = VERDICT_PASS;
          end else if (rel == RelTcpFlags && proto_d == ProtoTcp) begin
            syn_d     = b[1];
            fin_d     = b[0];
            verdict_d = VERDICT_PASS;
          end else begin
          end
        end else begin
        end
      end

      if (pos_c != 16'hFFFF) pos_d = pos_c + 16'd1;
      else pos_d = pos_c;

      if (s_axis_tlast) begin
        out_valid_d = 1'b1;
        out_data_d  = {5'd0, udp_len_d, fin_d, syn_d, dport_d, sport_d, dst_ip_d, src_ip_d,
                       proto_d, ttl_d, frag_d, tot_len_d, verdict_d};
        pos_d       = '0;
        hdr_words_d = '0;
        verdict_d   = VERDICT_TRUNC;
        tot_len_d   = '0;
        frag_d      = '0;
        ttl_d       = '0;
        proto_d     = '0;
        src_ip_d    = '0;
        dst_ip_d    = '0;
        sport_d     = '0;
        dport_d     = '0;
        syn_d       = 1'b0;
        fin_d       = 1'b0;
        udp_len_d   = '0;
        scratch_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_words_q <= '0;
      verdict_q   <= VERDICT_TRUNC;
      tot_len_q   <= '0;
      frag_q      <= '0;
      ttl_q       <= '0;
      proto_q     <= '0;
      src_ip_q    <= '0;
      dst_ip_q    <= '0;
      sport_q     <= '0;
      dport_q     <= '0;
      syn_q       <= 1'b0;
      fin_q       <= 1'b0;
      udp_len_q   <= '0;
      scratch_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hdr_words_q <= hdr_words_d;
      verdict_q   <= verdict_d;
      tot_len_q   <= tot_len_d;
      frag_q      <= frag_d;
      ttl_q       <= ttl_d;
      proto_q     <= proto_d;
      src_ip_q    <= src_ip_d;
      dst_ip_q    <= dst_ip_d;
      sport_q     <= sport_d;
      dport_q     <= dport_d;
      syn_q       <= syn_d;
      fin_q       <= fin_d;
      udp_len_q   <= udp_len_d;
      scratch_q   <= scratch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for eth_ipv4_l4_header_filter_top: directed and random
// Ethernet/IPv4/TCP/UDP frames checked against an in-bench filter predictor.
// Depends on eipf_pkg and the RTL only.
`timescale 1ns / 100ps

module tb;
  import eipf_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam logic [15:0] EthTypeIpv4 = {EthTypeHi, EthTypeLo};

  // result beat, lowest field at the bottom
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] udp_length;
    logic        tcp_fin;
    logic        tcp_syn;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [7:0]  ip_protocol;
    logic [7:0]  time_to_live;
    logic [12:0] frag_offset;
    logic [15:0] total_length;
    logic [3:0]  verdict;
  } filt_res_t;

  typedef struct {
    logic [15:0] eth_type;
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [15:0] frag_word;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] udp_len;
    logic [7:0]  tcp_flags;
    int unsigned payload;
    int unsigned cut;
  } frame_spec_t;

  typedef enum {
    FR_ONE_BYTE, FR_ETH_ONLY, FR_BAD_TYPE_HI, FR_BAD_TYPE_LO, FR_TCP_MAX, FR_UDP_ZERO,
    FR_UDP_VER, FR_IHL_ZERO, FR_IHL_MAX, FR_FRAG_MAX, FR_FRAG_FLAGS, FR_PROTO_MAX,
    FR_PROTO_ZERO, FR_TCP_CUT, FR_UDP_CUT, FR_NO_SOF, FR_RESTART, FR_LONG
  } frame_kind_e;

  typedef struct {
    frame_kind_e kind;
    logic        lit_ok;
    verdict_e    lit_verdict;
  } dir_row_t;

  dir_row_t dir_table [18] = '{
    '{FR_ONE_BYTE,    1'b1, VERDICT_TRUNC},
    '{FR_ETH_ONLY,    1'b1, VERDICT_TRUNC},
    '{FR_BAD_TYPE_HI, 1'b1, VERDICT_NOT_IPV4},
    '{FR_BAD_TYPE_LO, 1'b1, VERDICT_NOT_IPV4},
    '{FR_TCP_MAX,     1'b0, VERDICT_PASS},
    '{FR_UDP_ZERO,    1'b0, VERDICT_PASS},
    '{FR_UDP_VER,     1'b0, VERDICT_PASS},
    '{FR_IHL_ZERO,    1'b0, VERDICT_PASS},
    '{FR_IHL_MAX,     1'b0, VERDICT_PASS},
    '{FR_FRAG_MAX,    1'b0, VERDICT_PASS},
    '{FR_FRAG_FLAGS,  1'b0, VERDICT_PASS},
    '{FR_PROTO_MAX,   1'b0, VERDICT_PASS},
    '{FR_PROTO_ZERO,  1'b0, VERDICT_PASS},
    '{FR_TCP_CUT,     1'b0, VERDICT_PASS},
    '{FR_UDP_CUT,     1'b0, VERDICT_PASS},
    '{FR_NO_SOF,      1'b0, VERDICT_PASS},
    '{FR_RESTART,     1'b0, VERDICT_PASS},
    '{FR_LONG,        1'b0, VERDICT_PASS}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // data_byte
  logic s_axis_tuser = 1'b0;       // frame_start
  logic s_axis_tlast = 1'b0;       // frame_end
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // verdict, total_length, frag_offset, time_to_live, ip_protocol, source_ip,
  // dest_ip, source_port, dest_port, tcp_syn, tcp_fin, udp_length, zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  eth_ipv4_l4_header_filter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // filter settings as the predictor sees them
  logic [31:0] src_ip_q = '0;
  logic        src_en_q = 1'b0;
  logic [31:0] dst_ip_q = '0;
  logic        dst_en_q = 1'b0;
  logic [15:0] sport_q = '0;
  logic [15:0] dport_q = '0;

  // per-frame parse state
  logic [15:0] pos_q = '0;
  logic [3:0]  ihl_q = '0;
  verdict_e    verdict_q = VERDICT_TRUNC;
  filt_res_t   cap_q = '0;
  logic [7:0]  held_q = '0;

  filt_res_t   verdict_q_fifo[$];
  logic [7:0]  frame_bytes[$];
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        sink_hold = 1'b0;
  int unsigned mismatch_cnt = 0;

  task automatic clear_frame_state();
    pos_q = '0;
    ihl_q = '0;
    verdict_q = VERDICT_TRUNC;
    cap_q = '0;
    held_q = '0;
  endtask

  task automatic filter_step(input logic [7:0] b, input logic sof, input logic eof,
                             input logic use_lit, input verdict_e lit_v);
    logic [3:0]  words;
    logic [15:0] l4_start;
    logic [15:0] rel;
    filt_res_t   want;
    if (sof) clear_frame_state();
    if (verdict_q == VERDICT_TRUNC) begin
      if (pos_q == PosEthTypeHi) begin
        if (b != EthTypeHi) verdict_q = VERDICT_NOT_IPV4;
      end else if (pos_q == PosEthTypeLo) begin
        if (b != EthTypeLo) verdict_q = VERDICT_NOT_IPV4;
      end else if (pos_q == PosVerIhl) begin
        ihl_q = b[3:0];
      end else if (pos_q == PosTotLenHi || pos_q == PosFragHi) begin
        held_q = b;
      end else if (pos_q == PosTotLenLo) begin
        cap_q.total_length = {held_q, b};
      end else if (pos_q == PosFragLo) begin
        cap_q.frag_offset = {held_q[4:0], b};
      end else if (pos_q == PosTtl) begin
        cap_q.time_to_live = b;
      end else if (pos_q == PosProto) begin
        cap_q.ip_protocol = b;
      end else if (pos_q >= PosSrc0 && pos_q <= PosSrc3) begin
        cap_q.source_ip = {cap_q.source_ip[23:0], b};
        if (pos_q == PosSrc3 && src_en_q && cap_q.source_ip != src_ip_q)
          verdict_q = VERDICT_SRC_IP;
      end else if (pos_q >= PosDst0 && pos_q <= PosDst3) begin
        cap_q.dest_ip = {cap_q.dest_ip[23:0], b};
        if (pos_q == PosDst3) begin
          if (dst_en_q && cap_q.dest_ip != dst_ip_q) verdict_q = VERDICT_DST_IP;
          else if (cap_q.frag_offset != '0) verdict_q = VERDICT_FRAG;
          else if (cap_q.ip_protocol != ProtoTcp && cap_q.ip_protocol != ProtoUdp)
            verdict_q = VERDICT_PROTO;
        end
      end else if (pos_q >= PosL4Min) begin
        words = (ihl_q < MinIhl) ? MinIhl : ihl_q;
        l4_start = 16'(IpStart) + 16'(words) * 16'd4;
        if (pos_q >= l4_start) begin
          rel = pos_q - l4_start;
          if (rel == RelSportHi || rel == RelDportHi || rel == RelUdpLenHi) begin
            held_q = b;
          end else if (rel == RelSportLo) begin
            cap_q.source_port = {held_q, b};
            if (sport_q != '0 && cap_q.source_port != sport_q) verdict_q = VERDICT_SPORT;
          end else if (rel == RelDportLo) begin
            cap_q.dest_port = {held_q, b};
            if (dport_q != '0 && cap_q.dest_port != dport_q) verdict_q = VERDICT_DPORT;
          end else if (rel == RelUdpLenLo && cap_q.ip_protocol == ProtoUdp) begin
            cap_q.udp_length = {held_q, b};
            verdict_q = VERDICT_PASS;
          end else if (rel == RelTcpFlags && cap_q.ip_protocol == ProtoTcp) begin
            cap_q.tcp_syn = b[1];
            cap_q.tcp_fin = b[0];
            verdict_q = VERDICT_PASS;
          end
        end
      end
    end
    if (pos_q != 16'hFFFF) pos_q = pos_q + 16'd1;
    if (eof) begin
      want = cap_q;
      want.verdict = verdict_q;
      if (use_lit) begin
        want = '0;
        want.verdict = lit_v;
      end
      verdict_q_fifo.push_back(want);
      clear_frame_state();
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SRC_IP_MATCH:   src_ip_q = data;
      CFG_SRC_IP_ENABLE:  src_en_q = data[0];
      CFG_DST_IP_MATCH:   dst_ip_q = data;
      CFG_DST_IP_ENABLE:  dst_en_q = data[0];
      CFG_SRC_PORT_MATCH: sport_q = data[15:0];
      CFG_DST_PORT_MATCH: dport_q = data[15:0];
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [7:0] b, input logic sof, input logic eof,
                           input logic use_lit, input verdict_e lit_v);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= sof;
    s_axis_tlast <= eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    filter_step(b, sof, eof, use_lit, lit_v);
  endtask

  task automatic send_frame(input logic sof_first, input int unsigned junk_len,
                            input logic use_lit, input verdict_e lit_v);
    for (int i = 0; i < junk_len; i++)
      send_beat(8'($urandom), i == 0, 1'b0, 1'b0, VERDICT_TRUNC);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_beat(frame_bytes[i], (i == 0) && sof_first, i == frame_bytes.size() - 1,
                use_lit, lit_v);
  endtask

  task automatic build_frame(input frame_spec_t s);
    int unsigned words;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(s.eth_type[15:8]);
    frame_bytes.push_back(s.eth_type[7:0]);
    frame_bytes.push_back(s.ver_ihl);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(s.tot_len[15:8]);
    frame_bytes.push_back(s.tot_len[7:0]);
    repeat (2) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(s.frag_word[15:8]);
    frame_bytes.push_back(s.frag_word[7:0]);
    frame_bytes.push_back(s.ttl);
    frame_bytes.push_back(s.proto);
    repeat (2) frame_bytes.push_back(8'($urandom));
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(s.src_ip[8*k +: 8]);
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(s.dst_ip[8*k +: 8]);
    words = 32'((s.ver_ihl[3:0] < MinIhl) ? MinIhl : s.ver_ihl[3:0]);
    repeat ((words - MinIhl) * 4) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(s.sport[15:8]);
    frame_bytes.push_back(s.sport[7:0]);
    frame_bytes.push_back(s.dport[15:8]);
    frame_bytes.push_back(s.dport[7:0]);
    if (s.proto == ProtoUdp) begin
      frame_bytes.push_back(s.udp_len[15:8]);
      frame_bytes.push_back(s.udp_len[7:0]);
      repeat (2) frame_bytes.push_back(8'($urandom));
    end else begin
      repeat (8) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'h50);
      frame_bytes.push_back(s.tcp_flags);
      repeat (6) frame_bytes.push_back(8'($urandom));
    end
    repeat (s.payload) frame_bytes.push_back(8'($urandom));
    if (s.cut != 0)
      while (frame_bytes.size() > s.cut) void'(frame_bytes.pop_back());
  endtask

  function automatic frame_spec_t base_spec();
    frame_spec_t s;
    s.eth_type = EthTypeIpv4;
    s.ver_ihl = {4'h4, MinIhl};
    s.tot_len = 16'($urandom);
    s.frag_word = '0;
    s.ttl = 8'($urandom);
    s.proto = ($urandom_range(1) != 0) ? ProtoTcp : ProtoUdp;
    s.src_ip = $urandom;
    s.dst_ip = $urandom;
    s.sport = 16'($urandom);
    s.dport = 16'($urandom);
    s.udp_len = 16'($urandom);
    s.tcp_flags = 8'($urandom);
    s.payload = $urandom_range(6);
    s.cut = 0;
    return s;
  endfunction

  function automatic logic [31:0] biased(input logic [31:0] want, input logic active);
    return (active && $urandom_range(3) != 0) ? want : $urandom;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || sink_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    filt_res_t got;
    filt_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (verdict_q_fifo.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result beat with nothing expected: 0x%0h", $realtime, got);
      end else begin
        want = verdict_q_fifo.pop_front();
        check_field("verdict", 32'(got.verdict), 32'(want.verdict));
        check_field("total_length", 32'(got.total_length), 32'(want.total_length));
        check_field("frag_offset", 32'(got.frag_offset), 32'(want.frag_offset));
        check_field("time_to_live", 32'(got.time_to_live), 32'(want.time_to_live));
        check_field("ip_protocol", 32'(got.ip_protocol), 32'(want.ip_protocol));
        check_field("source_ip", got.source_ip, want.source_ip);
        check_field("dest_ip", got.dest_ip, want.dest_ip);
        check_field("source_port", 32'(got.source_port), 32'(want.source_port));
        check_field("dest_port", 32'(got.dest_port), 32'(want.dest_port));
        check_field("tcp_syn", 32'(got.tcp_syn), 32'(want.tcp_syn));
        check_field("tcp_fin", 32'(got.tcp_fin), 32'(want.tcp_fin));
        check_field("udp_length", 32'(got.udp_length), 32'(want.udp_length));
        check_field("pad", 32'(got.pad), 32'(want.pad));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    frame_spec_t s;
    logic        sof_first;
    int unsigned junk_len;
    int unsigned r;
    int unsigned n;
    logic [31:0] v_src;
    logic [31:0] v_dst;
    logic        v_sen;
    logic        v_den;
    logic [15:0] v_sp;
    logic [15:0] v_dp;

    clear_frame_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames, filters at reset values
    foreach (dir_table[i]) begin
      s = base_spec();
      sof_first = 1'b1;
      junk_len = 0;
      case (dir_table[i].kind)
        FR_ONE_BYTE:    s.cut = 1;
        FR_ETH_ONLY:    s.cut = 14;
        FR_BAD_TYPE_HI: s.eth_type = 16'h86DD;
        FR_BAD_TYPE_LO: s.eth_type = 16'h0801;
        FR_TCP_MAX: begin
          s.proto = ProtoTcp;
          s.tot_len = '1;
          s.ttl = '1;
          s.src_ip = '1;
          s.dst_ip = '1;
          s.sport = '1;
          s.dport = '1;
          s.tcp_flags = '1;
        end
        FR_UDP_ZERO: begin
          s.proto = ProtoUdp;
          s.tot_len = '0;
          s.ttl = '0;
          s.src_ip = '0;
          s.dst_ip = '0;
          s.sport = '0;
          s.dport = '0;
          s.udp_len = '0;
          s.ver_ihl = '0;
        end
        FR_UDP_VER: begin
          s.proto = ProtoUdp;
          s.ver_ihl = 8'hF5;
          s.udp_len = '1;
        end
        FR_IHL_ZERO:   s.ver_ihl = 8'h40;
        FR_IHL_MAX:    s.ver_ihl = 8'h4F;
        FR_FRAG_MAX:   s.frag_word = 16'hFFFF;
        FR_FRAG_FLAGS: s.frag_word = 16'hE000;
        FR_PROTO_MAX:  s.proto = 8'hFF;
        FR_PROTO_ZERO: s.proto = 8'h00;
        FR_TCP_CUT: begin
          s.proto = ProtoTcp;
          s.cut = 47;
        end
        FR_UDP_CUT: begin
          s.proto = ProtoUdp;
          s.cut = 39;
        end
        FR_NO_SOF:  sof_first = 1'b0;
        FR_RESTART: junk_len = 9;
        FR_LONG:    s.payload = 40;
        default: ;
      endcase
      build_frame(s);
      send_frame(sof_first, junk_len, dir_table[i].lit_ok, dir_table[i].lit_verdict);
    end

    // random phases: filter setting and idle pattern change per phase
    for (int phase = 0; phase < 5; phase++) begin
      s_axis_tvalid <= 1'b0;
      while (verdict_q_fifo.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      case (phase)
        0: begin
          v_src = '0; v_sen = 1'b0; v_dst = '0; v_den = 1'b0; v_sp = '0; v_dp = '0;
        end
        1: begin
          v_src = '1; v_sen = 1'b1; v_dst = '1; v_den = 1'b1; v_sp = '1; v_dp = '1;
        end
        2: begin
          v_src = '0; v_sen = 1'b1; v_dst = '0; v_den = 1'b1; v_sp = 16'd1; v_dp = 16'd1;
        end
        default: begin
          v_src = $urandom;
          v_sen = 1'($urandom);
          v_dst = $urandom;
          v_den = 1'($urandom);
          v_sp = ($urandom_range(1) != 0) ? 16'($urandom) : '0;
          v_dp = ($urandom_range(1) != 0) ? 16'($urandom) : '0;
        end
      endcase
      write_reg(CFG_SRC_IP_MATCH, v_src);
      write_reg(CFG_SRC_IP_ENABLE, {31'($urandom), v_sen});
      write_reg(CFG_DST_IP_MATCH, v_dst);
      write_reg(CFG_DST_IP_ENABLE, {31'($urandom), v_den});
      write_reg(CFG_SRC_PORT_MATCH, {16'($urandom), v_sp});
      write_reg(CFG_DST_PORT_MATCH, {16'($urandom), v_dp});
      write_reg(($urandom_range(1) != 0) ? CfgSpareLo : CfgSpareHi, $urandom);
      cfg_we_i <= 1'b0;

      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
        1: begin src_idle_pct = 47; sink_stall_pct <= 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct <= 47; end
        default: begin src_idle_pct = 11; sink_stall_pct <= 11; end
      endcase

      // sink holds off long enough for the output to back up into the input
      if (phase == 4) begin
        fork
          begin
            sink_hold <= 1'b1;
            repeat (400) @(posedge clk_i);
            sink_hold <= 1'b0;
          end
        join_none
      end

      for (int f = 0; f < ((phase == 4) ? 3 : 1); f++) begin
        s = base_spec();
        s.ver_ihl[7:4] = ($urandom_range(7) != 0) ? 4'h4 : 4'($urandom);
        if ($urandom_range(4) == 0) s.ver_ihl[3:0] = 4'($urandom);
        s.frag_word = {3'($urandom), 13'd0};
        s.src_ip = biased(src_ip_q, src_en_q);
        s.dst_ip = biased(dst_ip_q, dst_en_q);
        s.sport = 16'(biased({16'd0, sport_q}, sport_q != '0));
        s.dport = 16'(biased({16'd0, dport_q}, dport_q != '0));
        sof_first = 1'b1;
        junk_len = 0;
        r = $urandom_range(99);
        if (r < 60) begin
        end else if (r < 68) begin
          s.frag_word[12:0] = 13'($urandom_range(8191, 1));
        end else if (r < 74) begin
          s.proto = 8'($urandom);
        end else if (r < 82) begin
          s.cut = $urandom_range(60, 1);
        end else if (r < 87) begin
          s.eth_type = 16'($urandom);
        end else if (r < 92) begin
          s.eth_type = ($urandom_range(1) != 0) ? EthTypeIpv4 : 16'($urandom);
          s.cut = $urandom_range(40, 1);
          s.ver_ihl = 8'($urandom);
        end else if (r < 96) begin
          junk_len = $urandom_range(40, 1);
        end else begin
          sof_first = 1'b0;
        end
        build_frame(s);
        if (r >= 87 && r < 92) begin
          n = frame_bytes.size();
          for (int k = 0; k < n; k++) frame_bytes[k] = 8'($urandom);
        end
        send_frame(sof_first, junk_len, 1'b0, VERDICT_TRUNC);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (verdict_q_fifo.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
